@@ hdl/satq_pkg.sv @@
// Shared types, constants and address helpers for the sorted alarm timer queue.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package satq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_FIRE    = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int FIRE_W      = $clog2(MAX_FIRE + 1);
    localparam int TIME_W      = 32;
    localparam int DELAY_W     = 16;
    localparam int TAG_W       = 8;
    localparam int KIND_W      = 2;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [FIRE_W-1:0] t_fire;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [0:0]        t_alu_op;

    typedef struct packed {
        logic [TIME_W-1:0]  expiry;
        logic [TAG_W-1:0]   tag;
        logic [DELAY_W-1:0] delay;
    } t_entry;

    typedef struct packed {
        logic   we;
        t_addr  waddr;
        t_entry wdata;
        t_addr  raddr;
    } t_store_ctl;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_ADD  = 1'b1;

    localparam t_alu_op ALU_ADD = 1'b0;
    localparam t_alu_op ALU_SUB = 1'b1;

    localparam t_kind KIND_ADDED = 2'd0;
    localparam t_kind KIND_FULL  = 2'd1;
    localparam t_kind KIND_FIRED = 2'd2;
    localparam t_kind KIND_NONE  = 2'd3;

    // circular position: (head + offs) mod QUEUE_DEPTH
    function automatic t_addr phys_addr(t_addr head, t_addr offs);
        logic [ADDR_W:0] sum;
        sum = {1'b0, head} + {1'b0, offs};
        if (sum >= (ADDR_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (ADDR_W+1)'(QUEUE_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic t_addr next_addr(t_addr a);
        return phys_addr(a, t_addr'(1));
    endfunction

endpackage

@@ hdl/satq_req_if.sv @@
// Request channel: valid/ready handshake with tick/add payload.
// Depends on satq_pkg for field widths.
interface satq_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [satq_pkg::DELAY_W-1:0]  delay_seconds;
    logic [satq_pkg::TAG_W-1:0]    alarm_tag;

    modport source (output valid, output req_type, output delay_seconds,
                    output alarm_tag, input ready);
    modport sink   (input valid, input req_type, input delay_seconds,
                    input alarm_tag, output ready);
endinterface

@@ hdl/satq_rsp_if.sv @@
// Result channel: valid/ready handshake with result kind, fired alarm and last flag.
// Depends on satq_pkg for field widths.
interface satq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [satq_pkg::KIND_W-1:0]   result_kind;
    logic [satq_pkg::TAG_W-1:0]    fired_tag;
    logic [satq_pkg::DELAY_W-1:0]  fired_delay;
    logic                          last_result;

    modport source (output valid, output result_kind, output fired_tag,
                    output fired_delay, output last_result, input ready);
    modport sink   (input valid, input result_kind, input fired_tag,
                    input fired_delay, input last_result, output ready);
endinterface

@@ hdl/satq_alu.sv @@
// Shared 32-bit add/subtract unit; bit 32 of the result is carry or borrow.
// Depends on satq_pkg.
module satq_alu (
    input  satq_pkg::t_alu_op             i_op,
    input  logic [satq_pkg::TIME_W-1:0]   i_a,
    input  logic [satq_pkg::TIME_W-1:0]   i_b,
    output logic [satq_pkg::TIME_W:0]     o_res
);

    always_comb begin
        unique case (i_op)
            satq_pkg::ALU_ADD: o_res = {1'b0, i_a} + {1'b0, i_b};
            satq_pkg::ALU_SUB: o_res = {1'b0, i_a} - {1'b0, i_b};
            default:           o_res = '0;
        endcase
    end

endmodule

@@ hdl/satq_store.sv @@
// Alarm entry memory: one write port, one read port with registered read data.
// Depends on satq_pkg.
module satq_store (
    input  logic                  i_clk,
    input  satq_pkg::t_store_ctl  i_ctl,
    output satq_pkg::t_entry      o_rd
);

    satq_pkg::t_entry r_mem [satq_pkg::QUEUE_DEPTH];
    satq_pkg::t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        r_rd <= r_mem[i_ctl.raddr];
    end

    assign o_rd = r_rd;

endmodule

@@ hdl/sorted_alarm_timer_queue.sv @@
// Sorted alarm timer queue: sequencer, seconds counter and output register.
// Depends on satq_pkg, satq_req_if, satq_rsp_if, satq_alu and satq_store.
//
//   channel  dir  payload                                            requests
//   i_req    in   req_type, delay_seconds, alarm_tag                 one per item
//   o_rsp    out  result_kind, fired_tag, fired_delay, last_result   1..16 per item
//
// Steps per request, from one accept to the next. Add: work out the expiry, compare
// each entry at or after the insert point, walking from the tail and shifting it, and
// the entry just ahead of it if any, then write; a full queue goes to the result.
// Tick: advance the counter, fire due alarms in turn; the head read port sets the pace.
// A request is taken only in idle; the output register lets the next request in
// while the final result still waits. A stalled output holds the fire walk.
// Reset clears counter, count and head pointer; the entry memory needs no clearing.
module sorted_alarm_timer_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    satq_req_if.sink    i_req,
    satq_rsp_if.source  o_rsp
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_START    = 3'd1;
    localparam logic [2:0] S_ADD_CMP  = 3'd2;
    localparam logic [2:0] S_ADD_WR   = 3'd3;
    localparam logic [2:0] S_TICK_CMP = 3'd4;
    localparam logic [2:0] S_FIN      = 3'd5;

    logic [2:0]                       r_state, n_state;
    logic [satq_pkg::TIME_W-1:0]      r_now, n_now;
    satq_pkg::t_cnt                   r_count, n_count;
    satq_pkg::t_addr                  r_head, n_head;
    satq_pkg::t_addr                  r_j, n_j;
    satq_pkg::t_addr                  r_pos, n_pos;
    satq_pkg::t_fire                  r_fire, n_fire;
    logic                             r_have_pend, n_have_pend;
    logic                             r_type, n_type;
    logic [satq_pkg::DELAY_W-1:0]     r_delay, n_delay;
    logic [satq_pkg::TAG_W-1:0]       r_tag, n_tag;
    logic [satq_pkg::TIME_W-1:0]      r_new_exp, n_new_exp;
    logic [satq_pkg::TAG_W-1:0]       r_pend_tag, n_pend_tag;
    logic [satq_pkg::DELAY_W-1:0]     r_pend_delay, n_pend_delay;
    satq_pkg::t_kind                  r_fin_kind, n_fin_kind;

    logic                             r_out_valid;
    satq_pkg::t_kind                  r_out_kind;
    logic [satq_pkg::TAG_W-1:0]       r_out_tag;
    logic [satq_pkg::DELAY_W-1:0]     r_out_delay;
    logic                             r_out_last;

    logic                             out_free;
    logic                             out_load;
    satq_pkg::t_kind                  out_kind;
    logic [satq_pkg::TAG_W-1:0]       out_tag;
    logic [satq_pkg::DELAY_W-1:0]     out_delay;
    logic                             out_last;

    satq_pkg::t_alu_op                alu_op;
    logic [satq_pkg::TIME_W-1:0]      alu_a;
    logic [satq_pkg::TIME_W-1:0]      alu_b;
    logic [satq_pkg::TIME_W:0]        alu_res;

    satq_pkg::t_store_ctl             store_ctl;
    satq_pkg::t_entry                 rd_entry;

    satq_pkg::t_cnt                   cnt_m1;
    logic                             due;

    satq_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    satq_store u_store (
        .i_clk (i_clk),
        .i_ctl (store_ctl),
        .o_rd  (rd_entry)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign cnt_m1      = r_count - satq_pkg::CNT_W'(1);

    always_comb begin
        n_state      = r_state;
        n_now        = r_now;
        n_count      = r_count;
        n_head       = r_head;
        n_j          = r_j;
        n_pos        = r_pos;
        n_fire       = r_fire;
        n_have_pend  = r_have_pend;
        n_type       = r_type;
        n_delay      = r_delay;
        n_tag        = r_tag;
        n_new_exp    = r_new_exp;
        n_pend_tag   = r_pend_tag;
        n_pend_delay = r_pend_delay;
        n_fin_kind   = r_fin_kind;

        store_ctl        = '0;
        store_ctl.raddr  = r_head;
        alu_op           = satq_pkg::ALU_ADD;
        alu_a            = r_now;
        alu_b            = '0;
        out_load         = 1'b0;
        out_kind         = satq_pkg::KIND_FIRED;
        out_tag          = r_pend_tag;
        out_delay        = r_pend_delay;
        out_last         = 1'b0;
        due              = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_type  = i_req.req_type;
                    n_delay = i_req.delay_seconds;
                    n_tag   = i_req.alarm_tag;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_type == satq_pkg::REQ_ADD) begin
                    alu_b     = satq_pkg::TIME_W'(r_delay);
                    n_new_exp = alu_res[satq_pkg::TIME_W] ? '1
                                                          : alu_res[satq_pkg::TIME_W-1:0];
                    if (r_count == satq_pkg::CNT_W'(satq_pkg::QUEUE_DEPTH)) begin
                        n_fin_kind = satq_pkg::KIND_FULL;
                        n_state    = S_FIN;
                    end else if (r_count == '0) begin
                        n_pos   = '0;
                        n_state = S_ADD_WR;
                    end else begin
                        n_j             = cnt_m1[satq_pkg::ADDR_W-1:0];
                        store_ctl.raddr = satq_pkg::phys_addr(r_head,
                                              cnt_m1[satq_pkg::ADDR_W-1:0]);
                        n_state         = S_ADD_CMP;
                    end
                end else begin
                    alu_b       = satq_pkg::TIME_W'(1);
                    n_now       = alu_res[satq_pkg::TIME_W-1:0];
                    n_fire      = '0;
                    n_have_pend = 1'b0;
                    n_state     = S_TICK_CMP;
                end
            end
            S_ADD_CMP: begin
                alu_op = satq_pkg::ALU_SUB;
                alu_a  = rd_entry.expiry;
                alu_b  = r_new_exp;
                if (!alu_res[satq_pkg::TIME_W]) begin
                    // shift this entry one place toward the tail
                    store_ctl.we    = 1'b1;
                    store_ctl.waddr = satq_pkg::phys_addr(r_head,
                                          r_j + satq_pkg::ADDR_W'(1));
                    store_ctl.wdata = rd_entry;
                    if (r_j == '0) begin
                        n_pos   = '0;
                        n_state = S_ADD_WR;
                    end else begin
                        n_j             = r_j - satq_pkg::ADDR_W'(1);
                        store_ctl.raddr = satq_pkg::phys_addr(r_head,
                                              r_j - satq_pkg::ADDR_W'(1));
                    end
                end else begin
                    n_pos   = r_j + satq_pkg::ADDR_W'(1);
                    n_state = S_ADD_WR;
                end
            end
            S_ADD_WR: begin
                store_ctl.we           = 1'b1;
                store_ctl.waddr        = satq_pkg::phys_addr(r_head, r_pos);
                store_ctl.wdata.expiry = r_new_exp;
                store_ctl.wdata.tag    = r_tag;
                store_ctl.wdata.delay  = r_delay;
                n_count                = r_count + satq_pkg::CNT_W'(1);
                n_fin_kind             = satq_pkg::KIND_ADDED;
                n_state                = S_FIN;
            end
            S_TICK_CMP: begin
                alu_op = satq_pkg::ALU_SUB;
                alu_a  = r_now;
                alu_b  = rd_entry.expiry;
                due    = !alu_res[satq_pkg::TIME_W] && (r_count != '0) &&
                         (r_fire != satq_pkg::FIRE_W'(satq_pkg::MAX_FIRE));
                if (due) begin
                    if (!r_have_pend || out_free) begin
                        // release the previous firing, hold this one until the next decision
                        out_load        = r_have_pend;
                        n_pend_tag      = rd_entry.tag;
                        n_pend_delay    = rd_entry.delay;
                        n_have_pend     = 1'b1;
                        n_head          = satq_pkg::next_addr(r_head);
                        n_count         = cnt_m1;
                        n_fire          = r_fire + satq_pkg::FIRE_W'(1);
                        store_ctl.raddr = satq_pkg::next_addr(r_head);
                    end
                end else begin
                    n_fin_kind = r_have_pend ? satq_pkg::KIND_FIRED : satq_pkg::KIND_NONE;
                    n_state    = S_FIN;
                end
            end
            S_FIN: begin
                out_kind = r_fin_kind;
                out_last = 1'b1;
                if (r_fin_kind != satq_pkg::KIND_FIRED) begin
                    out_tag   = '0;
                    out_delay = '0;
                end
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_count     <= '0;
            r_head      <= '0;
            r_fire      <= '0;
            r_have_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_count     <= n_count;
            r_head      <= n_head;
            r_fire      <= n_fire;
            r_have_pend <= n_have_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j          <= n_j;
        r_pos        <= n_pos;
        r_type       <= n_type;
        r_delay      <= n_delay;
        r_tag        <= n_tag;
        r_new_exp    <= n_new_exp;
        r_pend_tag   <= n_pend_tag;
        r_pend_delay <= n_pend_delay;
        r_fin_kind   <= n_fin_kind;
        if (out_load) begin
            r_out_kind  <= out_kind;
            r_out_tag   <= out_tag;
            r_out_delay <= out_delay;
            r_out_last  <= out_last;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_kind = r_out_kind;
    assign o_rsp.fired_tag   = r_out_tag;
    assign o_rsp.fired_delay = r_out_delay;
    assign o_rsp.last_result = r_out_last;

endmodule
